[rtl/jse_pkg.sv]
// Shared types, character codes and encode helpers for the JSON string escaper.
`default_nettype none

package jse_pkg;

  localparam int unsigned MAX_BYTES = 12;
  localparam int unsigned ESC_BYTES = 6;

  typedef logic [MAX_BYTES-1:0][7:0] burst_t;
  typedef logic [ESC_BYTES-1:0][7:0] esc_t;
  typedef logic [3:0]                cnt_t;

  typedef struct packed {
    burst_t bytes;
    cnt_t   cnt;
    logic   hold;
  } enc_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_LF  = 8'h0a;
  localparam logic [7:0] CTL_FF  = 8'h0c;
  localparam logic [7:0] CTL_CR  = 8'h0d;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] CTL_LIMIT   = 8'h20;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'ha) begin
      return CH_ZERO + {4'h0, v};
    end else begin
      return CH_LOWER_A + {4'h0, v - 4'ha};
    end
  endfunction

  // \uXXXX, first byte at index 0
  function automatic esc_t u_escape(input logic [15:0] u);
    esc_t e;
    e[0] = CH_BSLASH;
    e[1] = CH_U;
    e[2] = hex_char(u[15:12]);
    e[3] = hex_char(u[11:8]);
    e[4] = hex_char(u[7:4]);
    e[5] = hex_char(u[3:0]);
    return e;
  endfunction

endpackage

`default_nettype wire

[rtl/jse_ifs.sv]
// Handshake channels: code unit requests in, escaped bytes out.
`default_nettype none

interface jse_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface jse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

[rtl/jse_enc.sv]
// Combinational encoder: one code unit plus held surrogate to a burst of bytes.
`default_nettype none

module jse_enc (
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  input  wire logic        held_valid,
  input  wire logic [15:0] held_unit,
  output jse_pkg::enc_t    enc
);
  import jse_pkg::*;

  esc_t        ub;
  cnt_t        ucnt;
  logic        uhold;
  logic        is_low;
  logic [10:0] plane;

  // single-unit encoding, as if nothing were held
  always_comb begin
    ub    = '0;
    ucnt  = '0;
    uhold = 1'b0;
    if (code_unit < {8'h00, ASCII_LIMIT}) begin
      if (code_unit < {8'h00, CTL_LIMIT} || code_unit[7:0] == CH_QUOTE ||
          code_unit[7:0] == CH_BSLASH) begin
        ub[0] = CH_BSLASH;
        ucnt  = 4'd2;
        case (code_unit[7:0])
          CH_QUOTE:  ub[1] = CH_QUOTE;
          CH_BSLASH: ub[1] = CH_BSLASH;
          CTL_BS:    ub[1] = CH_B;
          CTL_FF:    ub[1] = CH_F;
          CTL_LF:    ub[1] = CH_N;
          CTL_CR:    ub[1] = CH_R;
          CTL_TAB:   ub[1] = CH_T;
          default: begin
            ub[1] = CH_U;
            ub[2] = CH_ZERO;
            ub[3] = CH_ZERO;
            ub[4] = hex_char(code_unit[7:4]);
            ub[5] = hex_char(code_unit[3:0]);
            ucnt  = 4'd6;
          end
        endcase
      end else begin
        ub[0] = code_unit[7:0];
        ucnt  = 4'd1;
      end
    end else if (code_unit[15:11] == 5'b00000) begin
      ub[0] = {3'b110, code_unit[10:6]};
      ub[1] = {2'b10, code_unit[5:0]};
      ucnt  = 4'd2;
    end else if (code_unit[15:11] != 5'b11011) begin
      ub[0] = {4'b1110, code_unit[15:12]};
      ub[1] = {2'b10, code_unit[11:6]};
      ub[2] = {2'b10, code_unit[5:0]};
      ucnt  = 4'd3;
    end else if (!code_unit[10] && !last_unit) begin
      uhold = 1'b1;
    end else begin
      ub   = u_escape(code_unit);
      ucnt = 4'd6;
    end
  end

  assign is_low = (code_unit[15:10] == 6'b110111);
  // code point bits 20..10 of the pair: high surrogate payload plus one plane
  assign plane  = {1'b0, held_unit[9:0]} + 11'h040;

  always_comb begin
    enc = '0;
    if (held_valid && is_low) begin
      enc.bytes[0] = {5'b11110, plane[10:8]};
      enc.bytes[1] = {2'b10, plane[7:2]};
      enc.bytes[2] = {2'b10, plane[1:0], code_unit[9:6]};
      enc.bytes[3] = {2'b10, code_unit[5:0]};
      enc.cnt      = 4'd4;
    end else if (held_valid) begin
      enc.bytes[ESC_BYTES-1:0]         = u_escape(held_unit);
      enc.bytes[MAX_BYTES-1:ESC_BYTES] = ub;
      enc.cnt                          = 4'd6 + ucnt;
      enc.hold                         = uhold;
    end else begin
      enc.bytes[ESC_BYTES-1:0] = ub;
      enc.cnt                  = ucnt;
      enc.hold                 = uhold;
    end
  end

endmodule

`default_nettype wire

[rtl/jse_seq.sv]
// Result register: holds one burst and shifts it out a byte per cycle while the receiver is ready.
`default_nettype none

module jse_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  jse_pkg::burst_t       load_bytes,
  input  jse_pkg::cnt_t         load_cnt,
  output logic                  free,
  jse_byte_if.source            byte_ch
);
  import jse_pkg::*;

  burst_t data;
  cnt_t   rem;
  logic   take;

  assign take = byte_ch.valid && byte_ch.ready;
  // burst can be replaced when empty or when its final byte goes out now
  assign free = (rem == 4'd0) || (rem == 4'd1 && byte_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load && free) begin
      rem <= load_cnt;
    end else if (take) begin
      rem <= rem - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      data <= load_bytes;
    end else if (take) begin
      data <= {8'h00, data[MAX_BYTES-1:1]};
    end
  end

  assign byte_ch.valid    = (rem != 4'd0);
  assign byte_ch.out_byte = data[0];
  assign byte_ch.run_last = (rem == 4'd1);

endmodule

`default_nettype wire

[rtl/json_string_escaper_utf16_to_utf8_core.sv]
// JSON string escaper top level: UTF-16 code units in, escaped UTF-8 bytes out.
// A request passes through the input register and then the result register before its
// first byte can be taken. Output: one byte per cycle while the receiver is ready; an item
// yields 1 to 12 bytes, or none if it only holds a surrogate.
// The input register takes the next request while the result register drains.
// Reset (rst, synchronous): both stages empty, no surrogate held.
`default_nettype none

module json_string_escaper_utf16_to_utf8_core (
  input  wire logic   clk,
  input  wire logic   rst,
  jse_unit_if.sink    unit_ch,
  jse_byte_if.source  byte_ch
);
  import jse_pkg::*;

  logic        s1_valid;
  logic [15:0] s1_unit;
  logic        s1_last;
  logic        s1_move;
  logic        held_valid;
  logic [15:0] held_unit;
  logic        free;
  enc_t        enc;

  assign s1_move       = s1_valid && free;
  assign unit_ch.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (unit_ch.ready) begin
      s1_valid <= unit_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (unit_ch.valid && unit_ch.ready) begin
      s1_unit <= unit_ch.code_unit;
      s1_last <= unit_ch.last_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_unit  <= '0;
    end else if (s1_move) begin
      held_valid <= enc.hold;
      held_unit  <= enc.hold ? s1_unit : 16'h0000;
    end
  end

  jse_enc u_enc (
    .code_unit  (s1_unit),
    .last_unit  (s1_last),
    .held_valid (held_valid),
    .held_unit  (held_unit),
    .enc        (enc)
  );

  jse_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_move),
    .load_bytes (enc.bytes),
    .load_cnt   (enc.cnt),
    .free       (free),
    .byte_ch    (byte_ch)
  );

  // a held unit is always a high surrogate
  a_held_high: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> held_unit[15:10] == 6'b110110)
    else $error("held unit is not a high surrogate");

  // an item with no bytes leaves a surrogate held
  a_hold_on_empty: assert property (@(posedge clk) disable iff (rst)
    s1_move && enc.cnt == 4'd0 |=> held_valid)
    else $error("empty burst without held surrogate");

  // a burst is never cut short
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    byte_ch.valid && !byte_ch.run_last |=> byte_ch.valid)
    else $error("burst ended before its last byte");

  // burst length never exceeds the widest case
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    s1_move |-> enc.cnt <= 4'd12)
    else $error("burst length out of range");

endmodule

`default_nettype wire

[tb/sv/jse_escape_checker.sv]
// Checker for the JSON string escaper: predicts escaped bytes per code unit and compares.
`timescale 1ns / 1ps

module jse_escape_checker
  import jse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  jse_unit_if  unit_ch,
  jse_byte_if  byte_ch,
  output int   mismatch_count,
  output int   bytes_outstanding
);

  localparam logic [15:0] SURR_FIRST = 16'hd800;
  localparam logic [15:0] SURR_LAST  = 16'hdfff;
  localparam logic [15:0] LOW_FIRST  = 16'hdc00;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [20:0] PLANE1_BASE = 21'h10000;
  localparam string HEX_DIGITS = "0123456789abcdef";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } escaped_byte_t;

  escaped_byte_t expected_bytes[$];
  logic [7:0]    unit_bytes[$];
  logic [15:0]   held_high;
  logic          held_flag;

  initial begin
    mismatch_count = 0;
    held_high = '0;
    held_flag = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return HEX_DIGITS[n];
  endfunction

  function automatic void emit_u_escape(input logic [15:0] u);
    unit_bytes.push_back(CH_BSLASH);
    unit_bytes.push_back(CH_U);
    for (int i = 3; i >= 0; i--) unit_bytes.push_back(hex_digit(u[i*4 +: 4]));
  endfunction

  function automatic void encode_unit(input logic [15:0] u, input logic lst);
    if (u < ASCII_LIMIT) begin
      if (u < CTL_LIMIT || u[7:0] == CH_QUOTE || u[7:0] == CH_BSLASH) begin
        unit_bytes.push_back(CH_BSLASH);
        case (u[7:0])
          CH_QUOTE:  unit_bytes.push_back(CH_QUOTE);
          CH_BSLASH: unit_bytes.push_back(CH_BSLASH);
          CTL_BS:    unit_bytes.push_back(CH_B);
          CTL_FF:    unit_bytes.push_back(CH_F);
          CTL_LF:    unit_bytes.push_back(CH_N);
          CTL_CR:    unit_bytes.push_back(CH_R);
          CTL_TAB:   unit_bytes.push_back(CH_T);
          default: begin
            unit_bytes.push_back(CH_U);
            unit_bytes.push_back(CH_ZERO);
            unit_bytes.push_back(CH_ZERO);
            unit_bytes.push_back(hex_digit(u[7:4]));
            unit_bytes.push_back(hex_digit(u[3:0]));
          end
        endcase
      end else begin
        unit_bytes.push_back(u[7:0]);
      end
    end else if (u < TWO_BYTE_LIMIT) begin
      unit_bytes.push_back({3'b110, u[10:6]});
      unit_bytes.push_back({2'b10, u[5:0]});
    end else if (u < SURR_FIRST || u > SURR_LAST) begin
      unit_bytes.push_back({4'b1110, u[15:12]});
      unit_bytes.push_back({2'b10, u[11:6]});
      unit_bytes.push_back({2'b10, u[5:0]});
    end else if (u < LOW_FIRST && !lst) begin
      // high surrogate waits for its partner
      held_high = u;
      held_flag = 1'b1;
    end else begin
      emit_u_escape(u);
    end
  endfunction

  function automatic void predict_escape(input logic [15:0] u, input logic lst);
    logic [20:0] cp;
    unit_bytes.delete();
    if (held_flag) begin
      held_flag = 1'b0;
      if (u >= LOW_FIRST && u <= SURR_LAST) begin
        cp = {1'b0, held_high[9:0], u[9:0]} + PLANE1_BASE;
        unit_bytes.push_back({5'b11110, cp[20:18]});
        unit_bytes.push_back({2'b10, cp[17:12]});
        unit_bytes.push_back({2'b10, cp[11:6]});
        unit_bytes.push_back({2'b10, cp[5:0]});
      end else begin
        emit_u_escape(held_high);
        encode_unit(u, lst);
      end
      if (!held_flag) held_high = '0;
    end else begin
      encode_unit(u, lst);
    end
    foreach (unit_bytes[i])
      expected_bytes.push_back('{data: unit_bytes[i], last: (i == unit_bytes.size() - 1)});
  endfunction

  always @(posedge clk) begin
    escaped_byte_t want;
    if (rst) begin
      expected_bytes.delete();
      held_high = '0;
      held_flag = 1'b0;
    end else begin
      if (unit_ch.valid && unit_ch.ready)
        predict_escape(unit_ch.code_unit, unit_ch.last_unit);
      if (byte_ch.valid && byte_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h run_last %0b",
                                    byte_ch.out_byte, byte_ch.run_last));
        end else begin
          want = expected_bytes.pop_front();
          if (byte_ch.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      byte_ch.out_byte, want.data));
          if (byte_ch.run_last !== want.last)
            report_mismatch($sformatf("run_last %0b, expected %0b on byte %02h",
                                      byte_ch.run_last, want.last, want.data));
        end
      end
    end
    bytes_outstanding <= expected_bytes.size();
  end

endmodule

[tb/sv/tb_json_string_escaper_utf16_to_utf8_core.sv]
// Testbench top for the JSON string escaper: clock, reset, code unit stimulus and verdict.
`timescale 1ns / 1ps

module tb_json_string_escaper_utf16_to_utf8_core;

  localparam int RANDOM_UNITS = 320;
  localparam int TOTAL_UNITS  = 350;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_PHASES   = 3;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   bytes_outstanding;
  int   units_sent;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_cycles;

  jse_unit_if unit_ch();
  jse_byte_if byte_ch();

  json_string_escaper_utf16_to_utf8_core uut (
    .clk    (clk),
    .rst    (rst),
    .unit_ch(unit_ch),
    .byte_ch(byte_ch)
  );

  jse_escape_checker escape_checker (
    .clk              (clk),
    .rst              (rst),
    .unit_ch          (unit_ch),
    .byte_ch          (byte_ch),
    .mismatch_count   (mismatch_count),
    .bytes_outstanding(bytes_outstanding)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    unit_ch.valid = 1'b0;
    unit_ch.code_unit = '0;
    unit_ch.last_unit = 1'b0;
    byte_ch.ready = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 72;
    units_sent = 0;
    stall_cycles = 0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    byte_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (unit_ch.valid && unit_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // phase 0: sender light / receiver heavy idling, phase 1 swapped, phase 2 none
  task automatic set_idling();
    int phase;
    phase = units_sent * NUM_PHASES / TOTAL_UNITS;
    case (phase)
      0: begin
        send_idle_pct = 14;
        recv_idle_pct = 72;
      end
      1: begin
        send_idle_pct = 72;
        recv_idle_pct = 14;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_unit(input logic [15:0] cu, input logic lst);
    set_idling();
    if ($urandom_range(99) < send_idle_pct) begin
      unit_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    unit_ch.valid <= 1'b1;
    unit_ch.code_unit <= cu;
    unit_ch.last_unit <= lst;
    @(posedge clk);
    while (!unit_ch.ready) @(posedge clk);
    units_sent++;
  endtask

  initial begin
    logic [16:0] directed_units[] = '{
      {1'b0, 16'h0000}, {1'b0, 16'h001f}, {1'b0, 16'h0008}, {1'b0, 16'h000c},
      {1'b0, 16'h000a}, {1'b0, 16'h000d}, {1'b0, 16'h0009}, {1'b0, 16'h0022},
      {1'b0, 16'h005c}, {1'b0, 16'h007f}, {1'b0, 16'h0080}, {1'b0, 16'h07ff},
      {1'b0, 16'h0800}, {1'b0, 16'he000}, {1'b1, 16'hffff},
      // valid pairs, one closing the string
      {1'b0, 16'hd800}, {1'b0, 16'hdc00}, {1'b0, 16'hdbff}, {1'b1, 16'hdfff},
      // high surrogate at end of string, lone low
      {1'b1, 16'hdbff}, {1'b0, 16'hdfff},
      // held high broken by ascii, by another high, by a final high
      {1'b0, 16'hd800}, {1'b0, 16'h0041},
      {1'b0, 16'hd801}, {1'b0, 16'hdabc}, {1'b0, 16'h000b},
      {1'b0, 16'hd8ff}, {1'b1, 16'hdbff}
    };
    int kind;
    int target;
    logic lst;
    logic [15:0] cu;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_units[i]) send_unit(directed_units[i][15:0], directed_units[i][16]);

    target = units_sent + RANDOM_UNITS;
    while (units_sent < target) begin
      kind = $urandom_range(99);
      lst = ($urandom_range(7) == 0);
      if (kind < 25) begin
        send_unit(16'($urandom_range(16'h007e, 16'h0020)), lst);
      end else if (kind < 35) begin
        send_unit(16'($urandom_range(16'h001f, 16'h0000)), lst);
      end else if (kind < 50) begin
        send_unit(16'($urandom_range(16'h07ff, 16'h0080)), lst);
      end else if (kind < 65) begin
        cu = 16'($urandom_range(16'hffff, 16'h0800));
        // move surrogates out of the way
        if (cu[15:11] == 5'b11011) cu = cu ^ 16'h2000;
        send_unit(cu, lst);
      end else if (kind < 85) begin
        send_unit(16'($urandom_range(16'hdbff, 16'hd800)), 1'b0);
        send_unit(16'($urandom_range(16'hdfff, 16'hdc00)), lst);
      end else if (kind < 92) begin
        send_unit(16'($urandom_range(16'hdbff, 16'hd800)), lst);
      end else if (kind < 96) begin
        send_unit(16'($urandom_range(16'hdfff, 16'hdc00)), lst);
      end else begin
        send_unit(16'($urandom), lst);
      end
    end
    unit_ch.valid <= 1'b0;

    @(posedge clk);
    while (bytes_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    if (mismatch_count == 0 && bytes_outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/jse_pkg.sv
rtl/jse_ifs.sv
rtl/jse_enc.sv
rtl/jse_seq.sv
rtl/json_string_escaper_utf16_to_utf8_core.sv
tb/sv/jse_escape_checker.sv
tb/sv/tb_json_string_escaper_utf16_to_utf8_core.sv
